FILE: design/dpcm_prefix_code_encoder_assert.svh
// Assertion macros for the DPCM prefix-code encoder.
// All checks run on i_clk and are off while i_rst_n is low.
`ifndef DPCM_PREFIX_CODE_ENCODER_ASSERT_SVH
`define DPCM_PREFIX_CODE_ENCODER_ASSERT_SVH

// Same-cycle implication.
`define DPCM_ASSERT_NOW(lbl, cond, conseq) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |-> (conseq)) else $error("dpcm encoder assertion failed");

// Next-cycle implication.
`define DPCM_ASSERT_NEXT(lbl, cond, conseq) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |=> (conseq)) else $error("dpcm encoder assertion failed");

`endif

FILE: design/dpcm_pce_pkg.sv
package dpcm_pce_pkg;

    localparam int NumClasses  = 4;
    localparam int MaxBytes    = 3;
    localparam int QueueDepth  = 2;
    localparam int QPtrW       = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
    localparam int QCntW       = $clog2(QueueDepth + 1);

    // Class table: exclusive upper bound, suffix length, offset, prefix, prefix length
    localparam logic [8:0] ClassUpper  [NumClasses] = '{9'd2, 9'd6, 9'd22, 9'd256};
    localparam logic [3:0] ClassSbits  [NumClasses] = '{4'd1, 4'd2, 4'd4, 4'd8};
    localparam logic [7:0] ClassOffset [NumClasses] = '{8'd0, 8'd2, 8'd6, 8'd22};
    localparam logic [2:0] ClassPrefix [NumClasses] = '{3'd0, 3'd2, 3'd6, 3'd7};
    localparam logic [1:0] ClassPlen   [NumClasses] = '{2'd1, 2'd2, 2'd3, 2'd3};

    typedef struct packed {
        logic [10:0] bits;  // right-aligned code word
        logic [3:0]  len;   // 2..11
    } t_code;

    // One queue entry: the bytes a single pixel produces
    typedef struct packed {
        logic [MaxBytes-1:0][7:0] data;
        logic [1:0]               last_idx;  // index of the final byte
        logic                     seed;      // byte 0 is the seed
        logic                     done;      // final byte closes the image
    } t_cmd;

    function automatic t_code encode(input logic [7:0] folded);
        t_code      res;
        logic [7:0] sfx;
        int         c;
        c = NumClasses - 1;
        for (int i = NumClasses - 1; i >= 0; i--) begin
            if ({1'b0, folded} < ClassUpper[i]) begin
                c = i;
            end
        end
        sfx = folded - ClassOffset[c];
        res.len = ClassSbits[c] + {2'b00, ClassPlen[c]};
        res.bits = ({8'd0, ClassPrefix[c]} << ClassSbits[c])
                 | ({3'd0, sfx} & ~(11'h7ff << ClassSbits[c]));
        return res;
    endfunction

endpackage

FILE: design/dpcm_pce_front.sv
module dpcm_pce_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [7:0]           i_pixel,
    input  logic                 i_first,
    input  logic                 i_last,
    output logic                 o_push,
    output dpcm_pce_pkg::t_cmd   o_cmd
);

    logic [6:0] r_prev, n_prev;
    logic [6:0] r_pend, n_pend;
    logic [2:0] r_pcnt, n_pcnt;

    logic [6:0]         pix;
    logic [7:0]         diff, neg, folded;
    dpcm_pce_pkg::t_code code;
    logic [17:0]        acc, sh1, sh2;
    logic [4:0]         cnt;
    logic [2:0]         rem;
    logic [1:0]         nb;
    logic [7:0]         flush_byte;

    always_comb begin
        pix    = i_pixel[7:1];
        diff   = {1'b0, pix} - {1'b0, r_prev};
        neg    = 8'd0 - diff;
        folded = diff[7] ? ({neg[6:0], 1'b0} - 8'd1) : {diff[6:0], 1'b0};
        code   = dpcm_pce_pkg::encode(folded);
        acc    = ({11'd0, r_pend} << code.len) | {7'd0, code.bits};
        cnt    = {2'b00, r_pcnt} + {1'b0, code.len};
        sh1    = acc >> (cnt - 5'd8);
        sh2    = acc >> (cnt - 5'd16);
        rem    = '0;

        o_cmd  = '0;
        n_prev = pix;
        if (i_first) begin
            o_cmd.data[0] = {1'b0, pix};
            o_cmd.seed    = 1'b1;
            nb            = 2'd1;
            n_pend        = '0;
            n_pcnt        = '0;
        end else begin
            if (cnt >= 5'd16) begin
                o_cmd.data[0] = sh1[7:0];
                o_cmd.data[1] = sh2[7:0];
                nb            = 2'd2;
                rem           = 3'(cnt - 5'd16);
            end else if (cnt >= 5'd8) begin
                o_cmd.data[0] = sh1[7:0];
                nb            = 2'd1;
                rem           = 3'(cnt - 5'd8);
            end else begin
                nb            = 2'd0;
                rem           = cnt[2:0];
            end
            n_pend = acc[6:0] & ~(7'h7f << rem);
            n_pcnt = rem;
        end

        // flush: pending bits left-justified, zero padded
        flush_byte = {1'b0, n_pend} << (4'd8 - {1'b0, n_pcnt});
        if (i_last) begin
            o_cmd.data[nb] = flush_byte;
            o_cmd.done     = 1'b1;
            nb             = nb + 2'd1;
            n_pend         = '0;
            n_pcnt         = '0;
        end
        o_cmd.last_idx = nb - 2'd1;
        o_push = i_accept && (nb != 2'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
            r_pend <= '0;
            r_pcnt <= '0;
        end else if (i_accept) begin
            r_prev <= n_prev;
            r_pend <= n_pend;
            r_pcnt <= n_pcnt;
        end
    end

endmodule

FILE: design/dpcm_pce_queue.sv
module dpcm_pce_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  dpcm_pce_pkg::t_cmd   i_cmd,
    input  logic                 i_pop,
    output logic                 o_full,
    output logic                 o_empty,
    output dpcm_pce_pkg::t_cmd   o_head
);

    dpcm_pce_pkg::t_cmd r_mem [dpcm_pce_pkg::QueueDepth];
    logic [dpcm_pce_pkg::QPtrW-1:0] r_wptr, r_rptr;
    logic [dpcm_pce_pkg::QCntW-1:0] r_cnt;

    assign o_full  = (r_cnt == dpcm_pce_pkg::QCntW'(dpcm_pce_pkg::QueueDepth));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rptr];

    function automatic logic [dpcm_pce_pkg::QPtrW-1:0] bump(
        input logic [dpcm_pce_pkg::QPtrW-1:0] p);
        if (p == dpcm_pce_pkg::QPtrW'(dpcm_pce_pkg::QueueDepth - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= bump(r_wptr);
            end
            if (i_pop) begin
                r_rptr <= bump(r_rptr);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

FILE: design/dpcm_pce_back.sv
module dpcm_pce_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_empty,
    input  dpcm_pce_pkg::t_cmd   i_head,
    output logic                 o_pop,
    input  logic                 i_ready,
    output logic                 o_valid,
    output logic [7:0]           o_data,
    output logic                 o_seed,
    output logic                 o_done,
    output logic                 o_last
);

    logic [1:0] r_idx;
    logic       r_valid;
    logic [7:0] r_data;
    logic       r_seed, r_done, r_last;
    logic       load, at_last;

    assign load    = !r_valid || i_ready;
    assign at_last = (r_idx == i_head.last_idx);
    assign o_pop   = load && !i_empty && at_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (load) begin
            r_valid <= !i_empty;
            if (!i_empty) begin
                r_idx <= at_last ? 2'd0 : r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && !i_empty) begin
            r_data <= i_head.data[r_idx];
            r_seed <= i_head.seed && (r_idx == 2'd0);
            r_done <= i_head.done && at_last;
            r_last <= at_last;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_seed  = r_seed;
    assign o_done  = r_done;
    assign o_last  = r_last;

endmodule

FILE: design/dpcm_prefix_code_encoder.sv
// DPCM gray-pixel encoder with a four-class prefix code. Each accepted pixel
// (upper seven bits used) yields zero to three output bytes: a seed byte for
// the first pixel of an image, whole bytes of the MSB-first code stream as
// they complete, and a zero-padded flush byte after the last pixel. The front
// end classifies and packs a pixel in the cycle it is accepted, so a new pixel
// is taken every cycle while the two-entry transaction queue has room. The
// back end sends one byte per cycle while the receiver is ready, from a
// registered output stage, so the sustained pixel rate is set by the output
// port and by how many bytes each pixel gives. The first byte of a pixel
// passes through its queue entry and then the output register. tlast on the
// output marks the last byte caused by one input transaction.
`include "dpcm_prefix_code_encoder_assert.svh"

module dpcm_prefix_code_encoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // pixel input
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] pixel_value
    input  logic       s_axis_tuser,   // [0] first_of_image
    input  logic       s_axis_tlast,   // last_of_image
    // byte output
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic [1:0] m_axis_tuser,   // [0] is_seed, [1] image_done
    output logic       m_axis_tlast    // last_of_run
);

    logic               accept;
    logic               push, pop, full, empty;
    dpcm_pce_pkg::t_cmd cmd, head;
    logic               seed, done;

    assign s_axis_tready = !full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // front end: difference, zigzag fold, class lookup, bit packing
    dpcm_pce_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_pixel  (s_axis_tdata),
        .i_first  (s_axis_tuser),
        .i_last   (s_axis_tlast),
        .o_push   (push),
        .o_cmd    (cmd)
    );

    // decouples packing from the output stall
    dpcm_pce_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    // back end: serializes the bytes of each queue entry
    dpcm_pce_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_head  (head),
        .o_pop   (pop),
        .i_ready (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_data  (m_axis_tdata),
        .o_seed  (seed),
        .o_done  (done),
        .o_last  (m_axis_tlast)
    );

    assign m_axis_tuser = {done, seed};

    // a seed byte carries only seven pixel bits
    `DPCM_ASSERT_NOW(a_seed_msb, m_axis_tvalid && m_axis_tuser[0], !m_axis_tdata[7])
    // the flush byte closes its run and is never the seed
    `DPCM_ASSERT_NOW(a_done_last, m_axis_tvalid && m_axis_tuser[1],
                     m_axis_tlast && !m_axis_tuser[0])
    // bytes of one run leave back to back
    `DPCM_ASSERT_NEXT(a_run_gapless, m_axis_tvalid && m_axis_tready && !m_axis_tlast,
                      m_axis_tvalid)

endmodule

FILE: sim/dpcm_prefix_code_encoder_tb.sv
`timescale 1ns / 1ps

module dpcm_prefix_code_encoder_tb;

    // ---------------------------------------------------------------
    // Run constants
    // ---------------------------------------------------------------
    localparam int CLK_PERIOD     = 4;
    localparam int RESET_CYCLES   = 11;
    localparam int DRAIN_CYCLES   = 10;    // slack for the queue entry and the output register
    localparam int HOLD_CYCLES    = 60;    // long receiver hold-off, fills the block
    localparam int WATCHDOG_LIMIT = 400;   // cycles with no transaction on either side

    localparam int DIR_ROWS       = 21;
    localparam int RAND_PIXELS    = 105;
    localparam int HOLD_AT        = DIR_ROWS + 45;
    localparam int QUIET_AT       = DIR_ROWS + 85;
    localparam int TOTAL_PIXELS   = DIR_ROWS + RAND_PIXELS;

    // Row marker: expected bytes come from the predictor
    localparam int PREDICT        = -1;

    // tuser bit positions on the byte side
    localparam int USER_SEED      = 0;
    localparam int USER_DONE      = 1;

    // Code classes: exclusive limits of the folded value and the prefixes
    localparam int ZERO_LIMIT     = 2;
    localparam int SHORT_LIMIT    = 6;
    localparam int MID_LIMIT      = 22;
    localparam int PREFIX_ZERO    = 0;     // "0"
    localparam int PREFIX_SHORT   = 2;     // "10"
    localparam int PREFIX_MID     = 6;     // "110"
    localparam int PREFIX_LONG    = 7;     // "111"

    typedef enum int {
        CLS_ZERO,
        CLS_SHORT,
        CLS_MID,
        CLS_LONG
    } code_class_e;

    typedef struct packed {
        logic [7:0] data;
        logic       seed;
        logic       done;
        logic       run_end;
    } out_byte_t;

    typedef struct packed {
        logic [7:0]  pix;
        logic        first;
        logic        last;
        int          n_exp;      // PREDICT, or number of typed bytes
        logic [15:0] exp_data;   // typed bytes, first one in the low byte
    } dir_row_t;

    // ---------------------------------------------------------------
    // DUT signals
    // ---------------------------------------------------------------
    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;   // [7:0] pixel_value
    logic       s_axis_tuser  = 1'b0;    // [0] first_of_image
    logic       s_axis_tlast  = 1'b0;    // last_of_image
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;            // [7:0] out_byte
    logic [1:0] m_axis_tuser;            // [0] is_seed, [1] image_done
    logic       m_axis_tlast;            // last_of_run

    dpcm_prefix_code_encoder DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // Encoder state as the testbench sees it
    // ---------------------------------------------------------------
    logic [6:0] prev_pix  = 7'd0;
    int         pack_bits = 0;       // right-aligned, at most 7 bits
    int         pack_cnt  = 0;

    out_byte_t  pixel_bytes [3];     // bytes caused by the pixel just accepted
    int         pixel_nbytes;
    out_byte_t  due_bytes [$];       // bytes still owed by the DUT

    // Run control shared between processes
    bit         src_idle_en  = 1'b1;
    bit         sink_idle_en = 1'b1;
    bit         hold_req     = 1'b0;

    // Bookkeeping
    int         err_count     = 0;
    int         pixels_sent   = 0;
    int         images_closed = 0;
    int         bytes_seen    = 0;
    int         hold_count    = 0;
    int         idle_cycles   = 0;
    int         class_hits [4] = '{0, 0, 0, 0};
    logic [7:0] last_raw      = 8'h00;

    // Directed rows. Typed rows: after reset, seeds, aligned flush, seed with last.
    // Predicted rows walk the class edges and the extreme differences.
    dir_row_t directed_rows [DIR_ROWS] = '{
        '{8'h00, 1'b0, 1'b0, 0,       16'h0000},  // no seed yet, 2 bits pending only
        '{8'hFF, 1'b1, 1'b1, 2,       16'h007F},  // seed and last: seed, then zero flush
        '{8'h01, 1'b1, 1'b0, 1,       16'h0000},  // seed, low bit dropped
        '{8'h00, 1'b0, 1'b0, 0,       16'h0000},
        '{8'h01, 1'b0, 1'b0, 0,       16'h0000},  // low bit ignored: still zero diff
        '{8'h00, 1'b0, 1'b0, 0,       16'h0000},
        '{8'h00, 1'b0, 1'b1, 2,       16'h0000},  // completes a byte, aligned flush
        '{8'hFF, 1'b1, 1'b0, 1,       16'h007F},
        '{8'h00, 1'b0, 1'b0, PREDICT, 16'h0000},  // diff -127
        '{8'hFE, 1'b0, 1'b0, PREDICT, 16'h0000},  // diff +127
        '{8'hFC, 1'b0, 1'b0, PREDICT, 16'h0000},  // folded 1
        '{8'hFE, 1'b0, 1'b0, PREDICT, 16'h0000},  // folded 2
        '{8'hF8, 1'b0, 1'b0, PREDICT, 16'h0000},  // folded 5
        '{8'hFE, 1'b0, 1'b0, PREDICT, 16'h0000},  // folded 6
        '{8'hE8, 1'b0, 1'b0, PREDICT, 16'h0000},  // folded 21
        '{8'hFE, 1'b0, 1'b0, PREDICT, 16'h0000},  // folded 22
        '{8'h80, 1'b0, 1'b0, PREDICT, 16'h0000},
        '{8'h81, 1'b0, 1'b1, PREDICT, 16'h0000},  // partial flush
        '{8'h40, 1'b0, 1'b1, PREDICT, 16'h0000},  // last with no seed, prev kept
        '{8'h55, 1'b1, 1'b1, 2,       16'h002A},  // seed and last again
        '{8'hAA, 1'b0, 1'b0, PREDICT, 16'h0000}
    };

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------
    task automatic put_byte(input logic [7:0] data, input logic seed, input logic done);
        pixel_bytes[pixel_nbytes].data    = data;
        pixel_bytes[pixel_nbytes].seed    = seed;
        pixel_bytes[pixel_nbytes].done    = done;
        pixel_bytes[pixel_nbytes].run_end = 1'b0;
        pixel_nbytes++;
    endtask

    // Code one pixel: seed byte, completed stream bytes, flush byte.
    task automatic code_pixel(input logic [7:0] raw, input logic first, input logic last);
        logic [6:0] pix;
        logic [7:0] octet;
        int         diff;
        int         folded;
        int         word;
        int         wlen;
        int         acc;
        int         cnt;
        pix          = raw[7:1];
        pixel_nbytes = 0;
        if (first) begin
            put_byte({1'b0, pix}, 1'b1, 1'b0);
            pack_bits = 0;
            pack_cnt  = 0;
        end else begin
            // zigzag fold: d >= 0 -> 2d, d < 0 -> -2d-1
            diff   = int'(pix) - int'(prev_pix);
            folded = (diff >= 0) ? 2 * diff : -2 * diff - 1;
            if (folded < ZERO_LIMIT) begin
                wlen = 2;
                word = (PREFIX_ZERO << 1) | folded;
                class_hits[CLS_ZERO]++;
            end else if (folded < SHORT_LIMIT) begin
                wlen = 4;
                word = (PREFIX_SHORT << 2) | (folded - ZERO_LIMIT);
                class_hits[CLS_SHORT]++;
            end else if (folded < MID_LIMIT) begin
                wlen = 7;
                word = (PREFIX_MID << 4) | (folded - SHORT_LIMIT);
                class_hits[CLS_MID]++;
            end else begin
                wlen = 11;
                word = (PREFIX_LONG << 8) | (folded - MID_LIMIT);
                class_hits[CLS_LONG]++;
            end
            acc = (pack_bits << wlen) | word;
            cnt = pack_cnt + wlen;
            while (cnt >= 8) begin
                cnt   = cnt - 8;
                octet = 8'((acc >> cnt) & 8'hFF);
                put_byte(octet, 1'b0, 1'b0);
            end
            pack_bits = acc & ((1 << cnt) - 1);
            pack_cnt  = cnt;
        end
        prev_pix = pix;
        if (last) begin
            octet = 8'((pack_bits << (8 - pack_cnt)) & 8'hFF);
            put_byte(octet, 1'b0, 1'b1);
            pack_bits = 0;
            pack_cnt  = 0;
        end
    endtask

    // ---------------------------------------------------------------
    // Pixel source
    // ---------------------------------------------------------------
    // Offer one pixel, hold it until taken, then book what it owes.
    // A typed row replaces the predicted bytes; the predictor still runs
    // so that its state follows the block.
    task automatic send_pixel(input logic [7:0] raw, input logic first, input logic last,
                              input int n_exp, input logic [15:0] exp_data);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= raw;
        s_axis_tuser  <= first;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);

        code_pixel(raw, first, last);
        if (n_exp != PREDICT) begin
            pixel_nbytes = 0;
            for (int k = 0; k < n_exp; k++) begin
                put_byte(exp_data[8*k +: 8], first && (k == 0), last && (k == n_exp - 1));
            end
        end
        if (pixel_nbytes > 0) pixel_bytes[pixel_nbytes - 1].run_end = 1'b1;
        for (int k = 0; k < pixel_nbytes; k++) due_bytes.push_back(pixel_bytes[k]);

        pixels_sent++;
        if (last) images_closed++;
        last_raw = raw;

        // idle burst on the source side; otherwise the next pixel follows at once
        if (src_idle_en && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
    endtask

    // One image: seed, body, last. Some pixels get random flags to
    // break the framing (missing seed, seed mid-image, stray last).
    task automatic send_image();
        int         len;
        int         delta;
        logic [7:0] raw;
        logic       first;
        logic       last;
        len = $urandom_range(1, 10);
        for (int j = 0; j < len; j++) begin
            case ($urandom_range(0, 3))
                0:       delta = int'($urandom_range(0, 4)) - 2;
                1:       delta = int'($urandom_range(0, 24)) - 12;
                2:       delta = int'($urandom_range(0, 100)) - 50;
                default: delta = int'($urandom_range(0, 255));
            endcase
            raw   = last_raw + delta[7:0];
            first = (j == 0);
            last  = (j == len - 1);
            if ($urandom_range(0, 7) == 0) begin
                first = 1'($urandom_range(0, 1));
                last  = 1'($urandom_range(0, 1));
            end
            send_pixel(raw, first, last, PREDICT, 16'h0000);
        end
    endtask

    // Stop offering and let every owed byte come out, plus latency slack
    // for pixels that owe nothing.
    task automatic drain_pipeline();
        s_axis_tvalid <= 1'b0;
        while (due_bytes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------
    // Byte sink: ready pattern, with the long hold-off on request
    // ---------------------------------------------------------------
    initial begin : sink_ready
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_count++;
                hold_req = 1'b0;
            end else if (sink_idle_en && $urandom_range(0, 4) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
    end

    // ---------------------------------------------------------------
    // Checking
    // ---------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        err_count++;
        $display("%0t: %s mismatch, got %h, expected %h", $time, what, got, want);
    endtask

    always @(posedge i_clk) begin : byte_check
        out_byte_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            bytes_seen++;
            if (due_bytes.size() == 0) begin
                report_mismatch("unexpected byte", m_axis_tdata, 8'h00);
            end else begin
                want = due_bytes.pop_front();
                if (m_axis_tdata !== want.data)
                    report_mismatch("out_byte", m_axis_tdata, want.data);
                if (m_axis_tuser[USER_SEED] !== want.seed)
                    report_mismatch("is_seed", {7'd0, m_axis_tuser[USER_SEED]},
                                    {7'd0, want.seed});
                if (m_axis_tuser[USER_DONE] !== want.done)
                    report_mismatch("image_done", {7'd0, m_axis_tuser[USER_DONE]},
                                    {7'd0, want.done});
                if (m_axis_tlast !== want.run_end)
                    report_mismatch("last_of_run", {7'd0, m_axis_tlast},
                                    {7'd0, want.run_end});
            end
        end
    end

    // Watchdog: no transaction on either side for too long ends the run
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin : stimulus
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        for (int r = 0; r < DIR_ROWS; r++) begin
            send_pixel(directed_rows[r].pix, directed_rows[r].first, directed_rows[r].last,
                       directed_rows[r].n_exp, directed_rows[r].exp_data);
        end

        // random images with idling on both sides
        while (pixels_sent < HOLD_AT) send_image();

        // receiver holds off while the source keeps offering back to back
        src_idle_en = 1'b0;
        hold_req    = 1'b1;
        while (hold_req) send_image();
        src_idle_en = 1'b1;

        // source pauses until every owed byte is out
        drain_pipeline();

        while (pixels_sent < QUIET_AT) send_image();

        // closing stretch at full rate
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        while (pixels_sent < TOTAL_PIXELS) send_image();

        drain_pipeline();

        $display("run covered %0d pixels, %0d flushed images, %0d bytes, %0d receiver hold-offs",
                 pixels_sent, images_closed, bytes_seen, hold_count);
        $display("code classes seen: zero %0d, short %0d, mid %0d, long %0d",
                 class_hits[CLS_ZERO], class_hits[CLS_SHORT],
                 class_hits[CLS_MID], class_hits[CLS_LONG]);
        if (err_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

FILE: dpcm_prefix_code_encoder.f
+incdir+design
design/dpcm_pce_pkg.sv
design/dpcm_pce_front.sv
design/dpcm_pce_queue.sv
design/dpcm_pce_back.sv
design/dpcm_prefix_code_encoder.sv
sim/dpcm_prefix_code_encoder_tb.sv
